FILE: src/multitouch_slot_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Multitouch slot accumulator assertion macros
// Shared assertion forms; the enclosing module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTITOUCH_SLOT_ACCUMULATOR_DEFINES_SVH
`define MULTITOUCH_SLOT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multitouch slot accumulator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multitouch slot accumulator: next-cycle check failed");

`endif

FILE: src/msa_pkg.sv
// ----------------------------------------------------------------------------
// Multitouch slot accumulator package
// Event codes, command and configuration types shared by all modules.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM_W  = $clog2(SLOTS + 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [15:0] TYPE_ABS         = 16'd3;
  localparam logic [15:0] TYPE_SYN         = 16'd0;
  localparam logic [15:0] SYN_CODE_REPORT  = 16'd0;
  localparam logic [15:0] SYN_CODE_MT      = 16'd2;
  localparam logic [15:0] CODE_SLOT        = 16'h002F;
  localparam logic [15:0] CODE_TOUCH_MAJOR = 16'h0030;
  localparam logic [15:0] CODE_ORIENTATION = 16'h0034;
  localparam logic [15:0] CODE_POS_X       = 16'h0035;
  localparam logic [15:0] CODE_POS_Y       = 16'h0036;
  localparam logic [15:0] CODE_TOOL_TYPE   = 16'h0037;
  localparam logic [15:0] CODE_TRACK_ID    = 16'h0039;
  localparam logic [15:0] CODE_DISTANCE    = 16'h003B;

  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  // Reciprocal of 1000 scaled by 2^30; exact quotient for any 20-bit value.
  localparam logic [20:0] USEC_RECIP = 21'd1073742;
  localparam int          RECIP_SH   = 30;

  localparam logic [1:0] CFG_SLOTS_PROTOCOL = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_SLOTS   = 2'd1;
  localparam logic [1:0] CFG_X_SCALE        = 2'd2;
  localparam logic [1:0] CFG_Y_SCALE        = 2'd3;

  typedef enum logic [2:0] {
    CMD_POS_X,
    CMD_POS_Y,
    CMD_TRACK,
    CMD_DONE,
    CMD_TOUCH,
    CMD_REPORT
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_USE  = 2'd1,
    ST_DONE = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       arg;
  } cmd_t;

  typedef struct packed {
    logic        slots_protocol;
    logic [4:0]  active_slots;
    logic [19:0] x_scale;
    logic [19:0] y_scale;
  } cfg_t;

  function automatic logic [LIM_W-1:0] slot_limit(input logic [4:0] active);
    int a;
    a = int'(active);
    return LIM_W'((a > SLOTS) ? SLOTS : a);
  endfunction

endpackage

FILE: src/msa_front.sv
// ----------------------------------------------------------------------------
// Multitouch slot accumulator front end
// Accepts events, tracks the current slot and queues slot and report commands.
// ----------------------------------------------------------------------------
module msa_front
  import msa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_event_type,
  input  logic [15:0]        in_event_code,
  input  logic signed [31:0] in_event_value,
  input  logic [30:0]        in_time_sec,
  input  logic [19:0]        in_time_usec,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_data
);

  logic [31:0]      cur_slot_r;
  logic [31:0]      cur_slot_nxt;
  logic [LIM_W-1:0] lim;
  logic             in_range;
  logic             has_cmd;
  logic             accept;
  logic [31:0]      sec_ms;
  logic [40:0]      usec_prod;
  logic [31:0]      stamp;

  assign lim       = slot_limit(cfg.active_slots);
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign sec_ms    = {1'b0, in_time_sec} * MS_PER_SEC;
  assign usec_prod = in_time_usec * USEC_RECIP;
  assign stamp     = sec_ms + {21'd0, usec_prod[40:RECIP_SH]};

  always_comb begin
    cur_slot_nxt = cur_slot_r;
    if (in_event_type == TYPE_ABS) begin
      if ((cfg.slots_protocol && in_event_code == CODE_SLOT) ||
          (!cfg.slots_protocol && in_event_code == CODE_TRACK_ID)) begin
        cur_slot_nxt = in_event_value;
      end
    end else if (in_event_type == TYPE_SYN && in_event_code == SYN_CODE_MT &&
                 cfg.slots_protocol) begin
      cur_slot_nxt = cur_slot_r + 32'd1;
    end
  end

  assign in_range = !cur_slot_nxt[31] && (cur_slot_nxt < 32'(lim));

  always_comb begin
    has_cmd     = 1'b0;
    q_data.op   = CMD_TOUCH;
    q_data.slot = cur_slot_nxt[SLOT_W-1:0];
    q_data.arg  = in_event_value;
    if (in_event_type == TYPE_ABS) begin
      has_cmd = in_range;
      if (in_event_code == CODE_POS_X) begin
        q_data.op = CMD_POS_X;
      end else if (in_event_code == CODE_POS_Y) begin
        q_data.op = CMD_POS_Y;
      end else if (in_event_code == CODE_TRACK_ID) begin
        q_data.op = (cfg.slots_protocol && in_event_value[31]) ? CMD_DONE : CMD_TRACK;
      end else if ((in_event_code >= CODE_TOUCH_MAJOR &&
                    in_event_code <= CODE_ORIENTATION) ||
                   in_event_code == CODE_TOOL_TYPE ||
                   in_event_code == CODE_DISTANCE) begin
        q_data.op = CMD_TOUCH;
      end else begin
        has_cmd = 1'b0;
      end
    end else if (in_event_type == TYPE_SYN && in_event_code == SYN_CODE_REPORT) begin
      has_cmd    = 1'b1;
      q_data.op  = CMD_REPORT;
      q_data.arg = stamp;
    end
  end

  assign q_push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_slot_r <= '1;
    end else if (accept) begin
      cur_slot_r <= cur_slot_nxt;
    end
  end

endmodule

FILE: src/msa_fifo.sv
// ----------------------------------------------------------------------------
// Multitouch slot accumulator command queue
// Short first-in first-out buffer between the front end and the slot engine.
// ----------------------------------------------------------------------------
module msa_fifo
  import msa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t              data_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: src/msa_back.sv
// ----------------------------------------------------------------------------
// Multitouch slot accumulator slot engine
// Holds the slot store, applies commands and walks the slots on a report.
// ----------------------------------------------------------------------------
`include "multitouch_slot_accumulator_defines.svh"

module msa_back
  import msa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_message_kind,
  output logic signed [31:0] out_stamp_ms,
  output logic signed [31:0] out_contact_id,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic               out_last_of_report
);

  slot_st_t          status_r   [SLOTS];
  logic [31:0]       pos_x_r    [SLOTS];
  logic [31:0]       pos_y_r    [SLOTS];
  logic [31:0]       track_id_r [SLOTS];

  bk_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [31:0]       stamp_r, stamp_nxt;
  logic [51:0]       prod_x_r, prod_x_nxt;
  logic [51:0]       prod_y_r, prod_y_nxt;
  logic              neg_x_r, neg_x_nxt;
  logic              neg_y_r, neg_y_nxt;
  logic              kind_r, kind_nxt;
  logic [31:0]       id_r, id_nxt;
  logic              last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [31:0]       out_stamp_r, out_stamp_nxt;
  logic [31:0]       out_id_r, out_id_nxt;
  logic [31:0]       out_x_r, out_x_nxt;
  logic [31:0]       out_y_r, out_y_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LIM_W-1:0]  lim;
  logic              at_end;
  logic              live;
  logic              out_load;
  logic [SLOTS-1:0]  later_live;
  logic [31:0]       mag_x;
  logic [31:0]       mag_y;
  logic              st_we;
  logic [SLOT_W-1:0] st_idx;
  slot_st_t          st_val;
  logic              px_we;
  logic              py_we;
  logic              id_we;

  function automatic logic [31:0] sat_coord(input logic [51:0] prod, input logic neg);
    logic [35:0] p;
    p = prod[51:16];
    if (neg) begin
      return (p > 36'h080000000) ? 32'h80000000 : (32'd0 - p[31:0]);
    end
    return (p > 36'h07FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
  endfunction

  assign lim      = slot_limit(cfg.active_slots);
  assign at_end   = ((LIM_W'(idx_r) + LIM_W'(1)) == lim);
  assign live     = (status_r[idx_r] == ST_USE) || (status_r[idx_r] == ST_DONE);
  assign out_load = !out_valid_r || out_ready;
  assign mag_x    = pos_x_r[idx_r][31] ? (32'd0 - pos_x_r[idx_r]) : pos_x_r[idx_r];
  assign mag_y    = pos_y_r[idx_r][31] ? (32'd0 - pos_y_r[idx_r]) : pos_y_r[idx_r];

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      later_live[j] = (status_r[j] != ST_FREE) && (LIM_W'(j) < lim) &&
                      (SLOT_W'(j) > idx_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && q_data.op == CMD_REPORT && lim != '0) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (live) begin
          state_nxt = BK_EMIT;
        end else if (at_end) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (out_load) begin
          state_nxt = last_r ? BK_IDLE : BK_SCAN;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    idx_nxt    = idx_r;
    stamp_nxt  = stamp_r;
    prod_x_nxt = prod_x_r;
    prod_y_nxt = prod_y_r;
    neg_x_nxt  = neg_x_r;
    neg_y_nxt  = neg_y_r;
    kind_nxt   = kind_r;
    id_nxt     = id_r;
    last_nxt   = last_r;
    st_we      = 1'b0;
    st_idx     = q_data.slot;
    st_val     = ST_USE;
    px_we      = 1'b0;
    py_we      = 1'b0;
    id_we      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_stamp_nxt = out_stamp_r;
    out_id_nxt    = out_id_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_data.op)
            CMD_POS_X: begin
              st_we = 1'b1;
              px_we = 1'b1;
            end
            CMD_POS_Y: begin
              st_we = 1'b1;
              py_we = 1'b1;
            end
            CMD_TRACK: begin
              st_we = 1'b1;
              id_we = 1'b1;
            end
            CMD_DONE: begin
              st_we  = 1'b1;
              st_val = ST_DONE;
            end
            CMD_TOUCH: begin
              st_we = 1'b1;
            end
            CMD_REPORT: begin
              stamp_nxt = q_data.arg;
              idx_nxt   = '0;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        st_idx = idx_r;
        if (live) begin
          prod_x_nxt = mag_x * cfg.x_scale;
          prod_y_nxt = mag_y * cfg.y_scale;
          neg_x_nxt  = pos_x_r[idx_r][31];
          neg_y_nxt  = pos_y_r[idx_r][31];
          kind_nxt   = (status_r[idx_r] == ST_DONE);
          id_nxt     = track_id_r[idx_r];
          last_nxt   = ~|later_live;
          if (status_r[idx_r] == ST_DONE) begin
            st_we  = 1'b1;
            st_val = ST_FREE;
          end else if (!cfg.slots_protocol) begin
            st_we  = 1'b1;
            st_val = ST_DONE;
          end
        end else if (!at_end) begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      BK_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_stamp_nxt = stamp_r;
          out_id_nxt    = id_r;
          out_x_nxt     = kind_r ? 32'd0 : sat_coord(prod_x_r, neg_x_r);
          out_y_nxt     = kind_r ? 32'd0 : sat_coord(prod_y_r, neg_y_r);
          out_last_nxt  = last_r;
          if (!last_r) begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOTS; j++) begin
        status_r[j]   <= ST_FREE;
        pos_x_r[j]    <= '0;
        pos_y_r[j]    <= '0;
        track_id_r[j] <= '1;
      end
    end else begin
      if (st_we) begin
        status_r[st_idx] <= st_val;
      end
      if (px_we) begin
        pos_x_r[q_data.slot] <= q_data.arg;
      end
      if (py_we) begin
        pos_y_r[q_data.slot] <= q_data.arg;
      end
      if (id_we) begin
        track_id_r[q_data.slot] <= q_data.arg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r     <= stamp_nxt;
    prod_x_r    <= prod_x_nxt;
    prod_y_r    <= prod_y_nxt;
    neg_x_r     <= neg_x_nxt;
    neg_y_r     <= neg_y_nxt;
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    last_r      <= last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_id_r    <= out_id_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_message_kind   = out_kind_r;
  assign out_stamp_ms       = out_stamp_r;
  assign out_contact_id     = out_id_r;
  assign out_screen_x       = out_x_r;
  assign out_screen_y       = out_y_r;
  assign out_last_of_report = out_last_r;

  `MSA_ASSERT_NEXT(a_emit_hold, state_r == BK_EMIT && out_valid_r && !out_ready, state_r == BK_EMIT)
  `MSA_ASSERT_IMPL(a_stop_zero, out_valid_r && out_kind_r, out_x_r == '0 && out_y_r == '0)
  `MSA_ASSERT_IMPL(a_idx_range, state_r != BK_IDLE, LIM_W'(idx_r) < lim)

endmodule

FILE: src/multitouch_slot_accumulator.sv
// Ordering: slot updates pass through the command queue and reach the slot store when the
// engine pops them while idle; a report is popped while idle, the scan skips free slots to
// the first live one and the emit state loads the output register. Throughput: one event
// per cycle while the four-entry command queue is not full; a report then walks the slots
// up to the last reported slot, waiting on out_ready, and no command is popped meanwhile.
// Synchronous active-low reset: slots free, ids and current slot -1, default config.
// ----------------------------------------------------------------------------
// Multitouch slot accumulator
// Tracks evdev multitouch slots and emits one message per live slot on a report.
// ----------------------------------------------------------------------------
module multitouch_slot_accumulator
  import msa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_event_type,
  input  logic [15:0]        in_event_code,
  input  logic signed [31:0] in_event_value,
  input  logic [30:0]        in_time_sec,
  input  logic [19:0]        in_time_usec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_message_kind,
  output logic signed [31:0] out_stamp_ms,
  output logic signed [31:0] out_contact_id,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic               out_last_of_report
);

  cfg_t cfg_r;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slots_protocol <= 1'b1;
      cfg_r.active_slots   <= 5'd16;
      cfg_r.x_scale        <= 20'd65536;
      cfg_r.y_scale        <= 20'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOTS_PROTOCOL: cfg_r.slots_protocol <= cfg_wdata[0];
        CFG_ACTIVE_SLOTS:   cfg_r.active_slots   <= cfg_wdata[4:0];
        CFG_X_SCALE:        cfg_r.x_scale        <= cfg_wdata;
        CFG_Y_SCALE:        cfg_r.y_scale        <= cfg_wdata;
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  msa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .in_time_sec    (in_time_sec),
    .in_time_usec   (in_time_usec),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  msa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  msa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_message_kind   (out_message_kind),
    .out_stamp_ms       (out_stamp_ms),
    .out_contact_id     (out_contact_id),
    .out_screen_x       (out_screen_x),
    .out_screen_y       (out_screen_y),
    .out_last_of_report (out_last_of_report)
  );

endmodule
